// ----- rtl/huffman_bit_packer_assert.svh -----
// Assertion macros shared by the huffman bit packer RTL.
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

// Check a same-cycle implication on clk, off while arst_n is low.
`define HBP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle on clk, off while arst_n is low.
`define HBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hbp_pkg.sv -----
// Shared constants and types of the huffman bit packer.
package hbp_pkg;

	localparam int SYM_W       = 8;
	localparam int TABLE_DEPTH = 256;
	localparam int VALUE_W     = 32;
	localparam int BYTE_W      = 8;
	localparam int PEND_W      = 7;
	localparam int QDEPTH      = 4;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	// Status of the work queue between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} hbp_qstat_t;

endpackage

// ----- rtl/hbp_front.sv -----
// Front end: accepts beats, keeps the code table, looks up symbols for the queue.
module hbp_front #(
	parameter int LIM = 32,
	parameter int LW  = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                opcode,
	input  logic [hbp_pkg::SYM_W-1:0] symbol,
	input  logic [31:0]               code_value,
	input  logic [5:0]                code_length,
	input  hbp_pkg::hbp_qstat_t       qstat,
	output logic                      push,
	output logic [LIM+LW:0]           push_data
);
	import hbp_pkg::*;

	localparam logic [5:0] LIM_6 = 6'(LIM);

	logic [LIM+LW-1:0]      mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	logic              v_s1;
	logic              flush_s1;
	logic              hit_s1;
	logic [LIM+LW-1:0] rd_s1;

	logic           accept;
	logic           is_load;
	logic           is_work;
	logic [5:0]     len_sat;
	logic [LIM:0]   mask_w;
	logic [LIM-1:0] val_m;

	// Decode the opcode; unused codes are dropped
	always_comb begin
		is_load = 1'b0;
		is_work = 1'b0;
		unique case (opcode) inside
			OP_LOAD: begin
				is_load = 1'b1;
			end
			OP_ENCODE, OP_FLUSH: begin
				is_work = 1'b1;
			end
			default: begin
				is_load = 1'b0;
			end
		endcase
	end

	// Saturate the code length and keep only the code bits that fit it
	always_comb begin
		len_sat = (code_length > LIM_6) ? LIM_6 : code_length;
		mask_w  = ((LIM+1)'(1) << len_sat) - (LIM+1)'(1);
		val_m   = code_value[LIM-1:0] & mask_w[LIM-1:0];
	end

	// Hold the input while the lookup stage cannot drain into the queue
	assign in_stall  = v_s1 && qstat.full;
	assign accept    = in_valid && !in_stall;
	assign push      = v_s1 && !qstat.full;
	assign push_data = {flush_s1, hit_s1 ? rd_s1 : {(LIM+LW){1'b0}}};

	// Write loads into the table, read it for encode and flush beats
	always_ff @(posedge clk) begin
		if (accept && is_load) begin
			mem_q[symbol] <= {val_m, LW'(len_sat)};
		end
		if (accept && is_work) begin
			rd_s1    <= mem_q[symbol];
			hit_s1   <= vld_q[symbol];
			flush_s1 <= (opcode == OP_FLUSH);
		end
	end

	// Track loaded entries and the lookup stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept && is_load) begin
				vld_q[symbol] <= 1'b1;
			end
			if (!in_stall) begin
				v_s1 <= accept && is_work;
			end
		end
	end

endmodule

// ----- rtl/hbp_queue.sv -----
// Short work queue between the lookup front end and the packing back end.
module hbp_queue #(
	parameter int EW = 39
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [EW-1:0]       push_data,
	input  logic                pop,
	output logic [EW-1:0]       pop_data,
	output hbp_pkg::hbp_qstat_t qstat
);
	import hbp_pkg::*;

	localparam int AW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	logic [EW-1:0] ent_q [QDEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign qstat.full  = (cnt_q == CW'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = ent_q[rptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/hbp_back.sv -----
// Back end: merges codes into the bit accumulator and emits packed bytes.
module hbp_back #(
	parameter int LIM = 32,
	parameter int LW  = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hbp_pkg::hbp_qstat_t        qstat,
	input  logic [LIM+LW:0]            head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [hbp_pkg::BYTE_W-1:0] out_byte,
	output logic                       byte_valid,
	output logic [2:0]                 pad_bits,
	output logic                       last
);
	import hbp_pkg::*;

	localparam int ACCW = PEND_W + LIM;
	localparam int RW   = $clog2(ACCW + 1);

	logic [ACCW-1:0] word_q;
	logic [RW-1:0]   rem_q;
	logic            ov_q;

	logic              h_flush;
	logic [LIM-1:0]    h_val;
	logic [LW-1:0]     h_len;
	logic              full_byte;
	logic              out_free;
	logic              emit;
	logic [7:0]        pmask;
	logic [PEND_W-1:0] acc;
	logic [ACCW-1:0]   merged;
	logic [RW-1:0]     rem_sum;
	logic [RW-1:0]     sh;
	logic [ACCW-1:0]   shifted;
	logic              emit_last;
	logic [3:0]        pad_w;
	logic [2:0]        pad3;
	logic              fl_any;
	logic [7:0]        fl_byte;

	assign h_flush = head[LIM+LW];
	assign h_val   = head[LW +: LIM];
	assign h_len   = head[LW-1:0];

	// Pick the action: emit a full byte first, else take the next queue entry
	always_comb begin
		full_byte = (rem_q >= RW'(BYTE_W));
		out_free  = !ov_q || !out_stall;
		emit      = full_byte && out_free;
		pop       = !full_byte && !qstat.empty && (!h_flush || out_free);
	end

	// Append the code below the pending bits
	always_comb begin
		pmask   = (8'd1 << rem_q[2:0]) - 8'd1;
		acc     = word_q[PEND_W-1:0] & pmask[PEND_W-1:0];
		merged  = (ACCW'(acc) << h_len) | ACCW'(h_val);
		rem_sum = rem_q + RW'(h_len);
	end

	// Take the oldest full byte off the top of the pending bits
	always_comb begin
		sh        = rem_q - RW'(BYTE_W);
		shifted   = word_q >> sh;
		emit_last = (sh < RW'(BYTE_W));
	end

	// Pad the partial byte for a flush
	always_comb begin
		pad_w   = 4'(BYTE_W) - {1'b0, rem_q[2:0]};
		pad3    = pad_w[2:0];
		fl_any  = (rem_q[2:0] != 3'd0);
		fl_byte = {1'b0, acc} << pad3;
	end

	// Advance the accumulator and the output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			word_q <= '0;
			rem_q  <= '0;
		end else if (emit) begin
			ov_q  <= 1'b1;
			rem_q <= sh;
		end else if (pop && h_flush) begin
			ov_q   <= 1'b1;
			word_q <= '0;
			rem_q  <= '0;
		end else begin
			if (pop) begin
				word_q <= merged;
				rem_q  <= rem_sum;
			end
			if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Load the output beat
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte   <= shifted[BYTE_W-1:0];
			byte_valid <= 1'b1;
			pad_bits   <= 3'd0;
			last       <= emit_last;
		end else if (pop && h_flush) begin
			out_byte   <= fl_byte;
			byte_valid <= fl_any;
			pad_bits   <= fl_any ? pad3 : 3'd0;
			last       <= 1'b1;
		end
	end

	assign out_valid = ov_q;

endmodule

// ----- rtl/huffman_bit_packer.sv -----
// Top level of the huffman bit packer: code table, work queue and byte packer.
//
// Input channel (in_valid / in_stall): one beat per cycle carrying opcode,
// symbol, code_value and code_length. A load writes the 256-entry code table
// at once; an encode or flush takes a table lookup and enters a four-entry
// work queue. Input beats are taken every cycle while the queue has room.
// Output channel (out_valid / out_stall): one packed byte per beat, first code
// bit in bit 7, with last set on the final byte of an item. A flush always
// gives one beat (byte_valid low when nothing was pending).
// Path: an encode or flush beat that is taken passes the lookup stage register
// and the work queue; a flush then loads the output register directly, while
// an encode merges into the accumulator, whose full bytes load the output
// register. The packer takes one queue entry or emits one completed byte at a
// time, completed bytes first, so long codes (up to four bytes per item) are
// paced by the single byte extractor; the queue soaks up short bursts of them.
// Reset (arst_n low) marks all table entries empty and clears the queue and the
// accumulator. While out_stall is high the output beat holds, the packer stops
// once a full byte or a flush waits, and in_stall rises once the queue is full.
`include "huffman_bit_packer_assert.svh"

module huffman_bit_packer #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] symbol,
	input  logic [31:0] code_value,
	input  logic [5:0] code_length,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic [2:0] pad_bits,
	output logic       last
);
	import hbp_pkg::*;

	localparam int LIM = (MAX_CODE_LEN > VALUE_W) ? VALUE_W : MAX_CODE_LEN;
	localparam int LW  = $clog2(LIM + 1);
	localparam int EW  = 1 + LIM + LW;

	hbp_qstat_t    qstat;
	logic          push;
	logic [EW-1:0] push_data;
	logic          pop;
	logic [EW-1:0] q_head;

	hbp_front #(.LIM(LIM), .LW(LW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.symbol     (symbol),
		.code_value (code_value),
		.code_length(code_length),
		.qstat      (qstat),
		.push       (push),
		.push_data  (push_data)
	);

	hbp_queue #(.EW(EW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (q_head),
		.qstat    (qstat)
	);

	hbp_back #(.LIM(LIM), .LW(LW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.byte_valid(byte_valid),
		.pad_bits  (pad_bits),
		.last      (last)
	);

	// Queue never overflows or underflows
	`HBP_ASSERT_SAME(a_push_room, push, !qstat.full, "work queue pushed while full")
	`HBP_ASSERT_SAME(a_pop_data, pop, !qstat.empty, "work queue popped while empty")
	// A taken flush shows up as the closing beat in the next cycle
	`HBP_ASSERT_NEXT(a_flush_beat, pop && q_head[EW-1], out_valid && last, "flush lost")
	// An empty flush beat is always final and unpadded
	`HBP_ASSERT_SAME(a_empty_flush, out_valid && !byte_valid, last && (pad_bits == 3'd0), "bad empty flush")

endmodule
